[sv/ehdf_pkg.sv]
// Shared types and constants for the degeneracy flag core.
// Holds the register index codes, the sequencer state type and the Q1.16 widths.
// Has no dependencies of its own.
package ehdf_pkg;

  localparam int unsigned QW = 17;
  localparam int unsigned CW = 8;
  localparam int unsigned FW = 16;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned DIV_STEPS = FW;
  localparam int unsigned MUL_STEPS = QW;

  localparam logic [QW-1:0] ONE_Q16 = QW'(1) << FW;
  localparam logic [CW-1:0] RUN_MAX = '1;

  typedef enum logic [ADDR_W-1:0] {
    REG_TRANS_THRESHOLD = 3'd0,
    REG_ROT_THRESHOLD   = 3'd1,
    REG_SMOOTHING_GAIN  = 3'd2,
    REG_ENTER_LEVEL     = 3'd3,
    REG_EXIT_LEVEL      = 3'd4,
    REG_ENTER_FRAMES    = 3'd5,
    REG_EXIT_FRAMES     = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PREP,
    ST_MULT,
    ST_UPDATE
  } state_e;

endpackage

[sv/ehdf_div.sv]
// Bit-serial restoring divider that forms one minus ratio over threshold in Q1.16.
// Produces one quotient bit per step; depends on ehdf_pkg.
module ehdf_div (
  input  logic                    clk_i,
  input  logic                    start_i,
  input  logic                    step_i,
  input  logic [ehdf_pkg::QW-1:0] ratio_i,
  input  logic [ehdf_pkg::QW-1:0] thr_i,
  output logic [ehdf_pkg::QW-1:0] term_o
);
  import ehdf_pkg::*;

  logic [QW-1:0] div_q, div_d;
  logic [QW-1:0] rem_q, rem_d;
  logic [FW-1:0] quo_q, quo_d;
  logic          ovf_q, ovf_d;
  logic [QW:0]   trial;
  logic          fits;

  assign trial = {rem_q, 1'b0};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    div_d = div_q;
    rem_d = rem_q;
    quo_d = quo_q;
    ovf_d = ovf_q;
    if (start_i) begin
      div_d = (thr_i == '0) ? QW'(1) : thr_i;
      ovf_d = ratio_i >= ((thr_i == '0) ? QW'(1) : thr_i);
      rem_d = ratio_i;
      quo_d = '0;
    end else if (step_i) begin
      rem_d = fits ? QW'(trial - {1'b0, div_q}) : trial[QW-1:0];
      quo_d = {quo_q[FW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign term_o = ovf_q ? '0 : QW'(ONE_Q16 - {1'b0, quo_q});

endmodule

[sv/ema_hysteresis_degeneracy_flag_core.sv]
// Top level of the degeneracy score smoother with hysteresis flag.
// Instantiates two ehdf_div dividers and uses ehdf_pkg.
//
// Input channel: trans_ratio_i and rot_ratio_i, Q1.16, qualified by in_valid_i;
// a transaction completes when in_valid_i is high and in_stall_o is low.
// Output channel: smoothed_score_o and degenerate_o under out_valid_o, taken
// when out_stall_i is low. Every input transaction yields one output transaction.
// Configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_addr_i;
// writes must be made only while the core is idle; the core does not enforce it.
// Sequence: the accepting edge loads both dividers, then ST_DIVIDE runs the two
// parallel bit-serial divisions, ST_PREP picks the raw score, ST_MULT runs the
// bit-serial moving average multiply and ST_UPDATE commits. The next input is
// taken once the core is back in ST_IDLE after the commit, so no new item is
// accepted before the last one commits; the serial divider and multiplier set
// the pace. The first frame after reset skips the multiply.
// A new item is accepted while an earlier result still waits in the output
// register. If the receiver stalls, the commit step holds until the output
// register is free, and the input side stays stalled meanwhile.
// Reset loads the default register values, clears the score history, the
// flag and both run counters, and empties the output register.
module ema_hysteresis_degeneracy_flag_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ehdf_pkg::QW-1:0]     trans_ratio_i,
  input  logic [ehdf_pkg::QW-1:0]     rot_ratio_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ehdf_pkg::QW-1:0]     smoothed_score_o,
  output logic                        degenerate_o,
  input  logic                        cfg_we_i,
  input  logic [ehdf_pkg::ADDR_W-1:0] cfg_addr_i,
  input  logic [ehdf_pkg::QW-1:0]     cfg_wdata_i
);
  import ehdf_pkg::*;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [QW-1:0] trans_thr_q, rot_thr_q, gain_q, enter_lvl_q, exit_lvl_q;
  logic [CW-1:0] enter_frm_q, exit_frm_q;

  logic          started_q, started_d;
  logic [QW-1:0] score_q, score_d;
  logic          flag_q, flag_d;
  logic [CW-1:0] enter_run_q, enter_run_d;
  logic [CW-1:0] exit_run_q, exit_run_d;

  logic [QW-1:0]        raw_q, raw_d;
  logic signed [QW:0]   diff_q, diff_d;
  logic signed [QW+2:0] acc_q, acc_d;
  logic [QW-1:0]        gsr_q, gsr_d;

  logic                 out_valid_q, out_valid_d;
  logic [QW-1:0]        out_score_q, out_score_d;
  logic                 out_flag_q, out_flag_d;

  logic                 div_start, div_step;
  logic [QW-1:0]        term_t, term_r, raw_pick, gain_sat, new_score;
  logic signed [QW+2:0] addend, acc_sum;
  logic [QW+2:0]        score_sum;
  logic [CW-1:0]        enter_inc, exit_inc;
  logic                 out_free, commit;

  ehdf_div u_div_trans (
    .clk_i   (clk_i),
    .start_i (div_start),
    .step_i  (div_step),
    .ratio_i (trans_ratio_i),
    .thr_i   (trans_thr_q),
    .term_o  (term_t)
  );

  ehdf_div u_div_rot (
    .clk_i   (clk_i),
    .start_i (div_start),
    .step_i  (div_step),
    .ratio_i (rot_ratio_i),
    .thr_i   (rot_thr_q),
    .term_o  (term_r)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign div_start  = (state_q == ST_IDLE) && in_valid_i;
  assign div_step   = (state_q == ST_DIVIDE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_UPDATE) && out_free;

  assign raw_pick  = (term_t > term_r) ? term_t : term_r;
  assign gain_sat  = (gain_q > ONE_Q16) ? ONE_Q16 : gain_q;
  assign addend    = gsr_q[0] ? {{2{diff_q[QW]}}, diff_q} : '0;
  assign acc_sum   = acc_q + addend;
  assign score_sum = {3'b000, score_q} + acc_q;
  assign new_score = started_q ? score_sum[QW-1:0] : raw_q;
  assign enter_inc = (enter_run_q == RUN_MAX) ? RUN_MAX : CW'(enter_run_q + 1'b1);
  assign exit_inc  = (exit_run_q == RUN_MAX) ? RUN_MAX : CW'(exit_run_q + 1'b1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = started_q ? ST_MULT : ST_UPDATE;
      end
      ST_MULT: begin
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    raw_d       = raw_q;
    diff_d      = diff_q;
    acc_d       = acc_q;
    gsr_d       = gsr_q;
    started_d   = started_q;
    score_d     = score_q;
    flag_d      = flag_q;
    enter_run_d = enter_run_q;
    exit_run_d  = exit_run_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_score_d = out_score_q;
    out_flag_d  = out_flag_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
      end
      ST_DIVIDE: begin
        cnt_d = (cnt_q == CNT_W'(DIV_STEPS - 1)) ? '0 : CNT_W'(cnt_q + 1'b1);
      end
      ST_PREP: begin
        raw_d  = raw_pick;
        diff_d = $signed({1'b0, raw_pick}) - $signed({1'b0, score_q});
        acc_d  = '0;
        gsr_d  = gain_sat;
        cnt_d  = '0;
      end
      ST_MULT: begin
        cnt_d = CNT_W'(cnt_q + 1'b1);
        gsr_d = gsr_q >> 1;
        acc_d = (cnt_q == CNT_W'(MUL_STEPS - 1)) ? acc_sum : (acc_sum >>> 1);
      end
      ST_UPDATE: begin
        if (out_free) begin
          started_d = 1'b1;
          score_d   = new_score;
          if (!flag_q) begin
            if (new_score > enter_lvl_q) begin
              if (enter_inc >= enter_frm_q) begin
                flag_d      = 1'b1;
                enter_run_d = '0;
              end else begin
                enter_run_d = enter_inc;
              end
            end else begin
              enter_run_d = '0;
            end
          end else begin
            if (new_score < exit_lvl_q) begin
              if (exit_inc >= exit_frm_q) begin
                flag_d     = 1'b0;
                exit_run_d = '0;
              end else begin
                exit_run_d = exit_inc;
              end
            end else begin
              exit_run_d = '0;
            end
          end
          out_valid_d = 1'b1;
          out_score_d = new_score;
          out_flag_d  = flag_d;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      score_q     <= '0;
      flag_q      <= 1'b0;
      enter_run_q <= '0;
      exit_run_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      started_q   <= started_d;
      score_q     <= score_d;
      flag_q      <= flag_d;
      enter_run_q <= enter_run_d;
      exit_run_q  <= exit_run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q       <= raw_d;
    diff_q      <= diff_d;
    acc_q       <= acc_d;
    gsr_q       <= gsr_d;
    out_score_q <= out_score_d;
    out_flag_q  <= out_flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_thr_q <= QW'(1311);
      rot_thr_q   <= QW'(1311);
      gain_q      <= QW'(32768);
      enter_lvl_q <= QW'(26214);
      exit_lvl_q  <= QW'(13107);
      enter_frm_q <= CW'(3);
      exit_frm_q  <= CW'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_TRANS_THRESHOLD: trans_thr_q <= cfg_wdata_i;
        REG_ROT_THRESHOLD:   rot_thr_q   <= cfg_wdata_i;
        REG_SMOOTHING_GAIN:  gain_q      <= cfg_wdata_i;
        REG_ENTER_LEVEL:     enter_lvl_q <= cfg_wdata_i;
        REG_EXIT_LEVEL:      exit_lvl_q  <= cfg_wdata_i;
        REG_ENTER_FRAMES:    enter_frm_q <= cfg_wdata_i[CW-1:0];
        REG_EXIT_FRAMES:     exit_frm_q  <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign smoothed_score_o = out_score_q;
  assign degenerate_o     = out_flag_q;

  a_out_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_UPDATE))
    else $error("Output became valid without a commit step.");

  a_flag_clears_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(flag_q) |-> (enter_run_q == '0 && exit_run_q == '0))
    else $error("Run counters not cleared when the flag changed.");

  a_mult_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULT) |-> (cnt_q < CNT_W'(MUL_STEPS)))
    else $error("Multiply step counter out of range.");

  a_flag_matches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (degenerate_o == flag_q && smoothed_score_o == score_q))
    else $error("Committed result differs from the updated state.");

endmodule

[tb/tb_top.sv]
// Testbench for ema_hysteresis_degeneracy_flag_core: a scripted table, then random phases.
// It checks each result against a built-in score smoother and hysteresis flag model,
// or against the value a checked script row expects. Depends on ehdf_pkg and the core RTL only.
module tb_top;
  import ehdf_pkg::*;

  localparam int unsigned RANDOM_FRAMES = 1900;
  localparam int unsigned SETTLE_CYCLES = 2;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam logic [ADDR_W-1:0] UNUSED_REG_ADDR = 3'd7;
  localparam logic [QW-1:0] RATIO_MAX = '1;

  typedef struct packed {
    logic [QW-1:0] score;
    logic          flag;
  } frame_result_t;

  typedef struct packed {
    logic [QW-1:0] tr;
    logic [QW-1:0] rr;
    logic          typed;
    frame_result_t want;
  } frame_req_t;

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [ADDR_W-1:0] addr;
    logic [QW-1:0]     data;
    logic [QW-1:0]     tr;
    logic [QW-1:0]     rr;
    logic              typed;
    frame_result_t     want;
  } script_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [QW-1:0]     trans_ratio_i;
  logic [QW-1:0]     rot_ratio_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [QW-1:0]     smoothed_score_o;
  logic              degenerate_o;
  logic              cfg_we_i;
  logic [ADDR_W-1:0] cfg_addr_i;
  logic [QW-1:0]     cfg_wdata_i;

  ema_hysteresis_degeneracy_flag_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .trans_ratio_i   (trans_ratio_i),
    .rot_ratio_i     (rot_ratio_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .smoothed_score_o(smoothed_score_o),
    .degenerate_o    (degenerate_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Shadow copy of the register file and of the smoother state.
  logic [QW-1:0] cfg_trans_thr = 17'd1311;
  logic [QW-1:0] cfg_rot_thr = 17'd1311;
  logic [QW-1:0] cfg_gain = 17'd32768;
  logic [QW-1:0] cfg_enter_level = 17'd26214;
  logic [QW-1:0] cfg_exit_level = 17'd13107;
  logic [CW-1:0] cfg_enter_frames = 8'd3;
  logic [CW-1:0] cfg_exit_frames = 8'd5;
  logic          score_started = 1'b0;
  logic [QW-1:0] avg_score = '0;
  logic          flag_state = 1'b0;
  logic [CW-1:0] enter_run = '0;
  logic [CW-1:0] exit_run = '0;

  frame_req_t    submitted_frames[$];
  frame_result_t pending_results[$];
  script_row_t   script [37];

  int mismatches = 0;
  int results_checked = 0;
  int degenerate_results = 0;
  int reg_writes = 0;
  int burst_left = 0;

  function automatic logic [QW-1:0] ratio_shortfall(input logic [QW-1:0] ratio,
                                                    input logic [QW-1:0] thr);
    logic [63:0] divisor;
    logic [63:0] quotient;
    divisor = (thr == '0) ? 64'd1 : 64'(thr);
    quotient = (64'(ratio) << FW) / divisor;
    if (quotient >= 64'(ONE_Q16)) return '0;
    return ONE_Q16 - quotient[QW-1:0];
  endfunction

  function automatic frame_result_t smooth_and_flag(input logic [QW-1:0] tr,
                                                    input logic [QW-1:0] rr);
    logic [QW-1:0] term_t;
    logic [QW-1:0] term_r;
    logic [QW-1:0] raw;
    logic [63:0]   gain;
    logic [63:0]   acc;
    term_t = ratio_shortfall(tr, cfg_trans_thr);
    term_r = ratio_shortfall(rr, cfg_rot_thr);
    raw = (term_t > term_r) ? term_t : term_r;
    if (!score_started) begin
      avg_score = raw;
      score_started = 1'b1;
    end else begin
      gain = (cfg_gain > ONE_Q16) ? 64'(ONE_Q16) : 64'(cfg_gain);
      acc = gain * 64'(raw) + (64'(ONE_Q16) - gain) * 64'(avg_score);
      avg_score = acc[FW+QW-1:FW];
    end
    if (!flag_state) begin
      if (avg_score > cfg_enter_level) begin
        if (enter_run != RUN_MAX) enter_run = enter_run + 1'b1;
        if (enter_run >= cfg_enter_frames) begin
          flag_state = 1'b1;
          enter_run = '0;
        end
      end else begin
        enter_run = '0;
      end
    end else begin
      if (avg_score < cfg_exit_level) begin
        if (exit_run != RUN_MAX) exit_run = exit_run + 1'b1;
        if (exit_run >= cfg_exit_frames) begin
          flag_state = 1'b0;
          exit_run = '0;
        end
      end else begin
        exit_run = '0;
      end
    end
    return '{score: avg_score, flag: flag_state};
  endfunction

  function automatic script_row_t frame_row(input logic [QW-1:0] tr, input logic [QW-1:0] rr);
    script_row_t row;
    row = '0;
    row.kind = ROW_FRAME;
    row.tr = tr;
    row.rr = rr;
    return row;
  endfunction

  function automatic script_row_t checked_row(input logic [QW-1:0] tr, input logic [QW-1:0] rr,
                                              input logic [QW-1:0] score, input logic flag);
    script_row_t row;
    row = frame_row(tr, rr);
    row.typed = 1'b1;
    row.want = '{score: score, flag: flag};
    return row;
  endfunction

  function automatic script_row_t write_row(input logic [ADDR_W-1:0] addr,
                                            input logic [QW-1:0] data);
    script_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.addr = addr;
    row.data = data;
    return row;
  endfunction

  function automatic logic [QW-1:0] pick_setting(input logic [ADDR_W-1:0] addr);
    int unsigned corner;
    corner = $urandom_range(0, 15);
    case (addr)
      REG_TRANS_THRESHOLD, REG_ROT_THRESHOLD: begin
        case (corner)
          0: return '0;
          1: return 17'd1;
          2: return ONE_Q16;
          3: return RATIO_MAX;
          default: return QW'($urandom_range(64, 8192));
        endcase
      end
      REG_SMOOTHING_GAIN: begin
        case (corner)
          0: return '0;
          1: return 17'd1;
          2: return ONE_Q16;
          3: return QW'($urandom_range(32'(ONE_Q16) + 1, 32'(RATIO_MAX)));
          default: return QW'($urandom_range(2048, 32'(ONE_Q16)));
        endcase
      end
      REG_ENTER_LEVEL, REG_EXIT_LEVEL: begin
        case (corner)
          0: return '0;
          1: return ONE_Q16;
          2: return RATIO_MAX;
          default: begin
            if (addr == REG_ENTER_LEVEL) return QW'($urandom_range(16384, 32'(ONE_Q16)));
            return QW'($urandom_range(0, 40000));
          end
        endcase
      end
      default: begin
        case (corner)
          0: return '0;
          1: return QW'(RUN_MAX);
          2: return QW'($urandom_range(0, 32'(RATIO_MAX)));
          default: return QW'($urandom_range(1, 6));
        endcase
      end
    endcase
  endfunction

  function automatic logic [QW-1:0] ratio_below(input logic [QW-1:0] thr);
    if (thr <= 17'd1) return '0;
    return QW'($urandom_range(0, 32'(thr) - 1));
  endfunction

  function automatic logic [QW-1:0] ratio_above(input logic [QW-1:0] thr);
    return QW'($urandom_range(32'(thr), 32'(RATIO_MAX)));
  endfunction

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [QW-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = addr;
    cfg_wdata_i = data;
    case (addr)
      REG_TRANS_THRESHOLD: cfg_trans_thr = data;
      REG_ROT_THRESHOLD:   cfg_rot_thr = data;
      REG_SMOOTHING_GAIN:  cfg_gain = data;
      REG_ENTER_LEVEL:     cfg_enter_level = data;
      REG_EXIT_LEVEL:      cfg_exit_level = data;
      REG_ENTER_FRAMES:    cfg_enter_frames = data[CW-1:0];
      REG_EXIT_FRAMES:     cfg_exit_frames = data[CW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_for_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (submitted_frames.size() != 0 || pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [QW-1:0] tr, input logic [QW-1:0] rr,
                            input logic typed, input frame_result_t want);
    int unsigned gap;
    @(negedge clk_i);
    submitted_frames.push_back('{tr: tr, rr: rr, typed: typed, want: want});
    in_valid_i = 1'b1;
    trans_ratio_i = tr;
    rot_ratio_i = rr;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 48);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        trans_ratio_i = QW'($urandom);
        rot_ratio_i = QW'($urandom);
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : receiver_stall
    int unsigned mode;
    int unsigned len;
    out_stall_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len = (mode == 3) ? $urandom_range(1, 40) : $urandom_range(1, 120);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall_i = 1'b0;
          1: out_stall_i = ($urandom_range(0, 3) == 0);
          2: out_stall_i = $urandom_range(0, 1);
          default: out_stall_i = 1'b1;
        endcase
      end
    end
  end

  // Results are compared before the frame accepted at the same edge is predicted.
  always @(posedge clk_i) begin
    frame_result_t want;
    frame_result_t got;
    frame_req_t    req;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, score %0d degenerate %0b",
                 $time, smoothed_score_o, degenerate_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (degenerate_o) degenerate_results++;
        if (smoothed_score_o !== want.score) begin
          $display("%0t: smoothed_score expected %0d, actual %0d",
                   $time, want.score, smoothed_score_o);
          mismatches++;
        end
        if (degenerate_o !== want.flag) begin
          $display("%0t: degenerate expected %0b, actual %0b", $time, want.flag, degenerate_o);
          mismatches++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      req = submitted_frames.pop_front();
      got = smooth_and_flag(trans_ratio_i, rot_ratio_i);
      pending_results.push_back(req.typed ? req.want : got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_frames;
    int unsigned script_frames;
    int unsigned phase_left;
    int unsigned seg_kind;
    int unsigned seg_len;
    logic [QW-1:0] tr;
    logic [QW-1:0] rr;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    trans_ratio_i = '0;
    rot_ratio_i = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    random_frames = 0;
    script_frames = 0;
    burst_left = $urandom_range(1, 24);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults first, then the degenerate corners, then oversized settings.
    script = '{
      checked_row('0, '0, ONE_Q16, 1'b0),
      checked_row('0, '0, ONE_Q16, 1'b0),
      checked_row('0, '0, ONE_Q16, 1'b1),
      checked_row(RATIO_MAX, RATIO_MAX, 17'd32768, 1'b1),
      checked_row(RATIO_MAX, RATIO_MAX, 17'd16384, 1'b1),
      checked_row(RATIO_MAX, RATIO_MAX, 17'd8192, 1'b1),
      checked_row(RATIO_MAX, RATIO_MAX, 17'd4096, 1'b1),
      checked_row(RATIO_MAX, RATIO_MAX, 17'd2048, 1'b1),
      checked_row(RATIO_MAX, RATIO_MAX, 17'd1024, 1'b1),
      checked_row(RATIO_MAX, RATIO_MAX, 17'd512, 1'b0),
      write_row(REG_TRANS_THRESHOLD, '0),
      write_row(REG_ROT_THRESHOLD, '0),
      write_row(REG_SMOOTHING_GAIN, RATIO_MAX),
      write_row(REG_ENTER_LEVEL, '0),
      write_row(REG_EXIT_LEVEL, ONE_Q16),
      write_row(REG_ENTER_FRAMES, '0),
      write_row(REG_EXIT_FRAMES, '0),
      checked_row('0, 17'd5, ONE_Q16, 1'b1),
      checked_row(17'd1, 17'd1, '0, 1'b0),
      checked_row(ONE_Q16, '0, ONE_Q16, 1'b1),
      write_row(REG_TRANS_THRESHOLD, RATIO_MAX),
      write_row(REG_ROT_THRESHOLD, ONE_Q16),
      write_row(REG_SMOOTHING_GAIN, 17'd1),
      write_row(REG_ENTER_LEVEL, ONE_Q16),
      write_row(REG_EXIT_LEVEL, RATIO_MAX),
      write_row(REG_ENTER_FRAMES, 17'h1FF),
      write_row(REG_EXIT_FRAMES, 17'h101),
      write_row(UNUSED_REG_ADDR, 17'h15555),
      frame_row(17'd100000, RATIO_MAX),
      frame_row(ONE_Q16, 17'd65535),
      frame_row(17'd12345, 17'd70000),
      frame_row('0, RATIO_MAX),
      frame_row(RATIO_MAX, RATIO_MAX),
      frame_row(17'd65535, 17'd1),
      write_row(REG_SMOOTHING_GAIN, '0),
      frame_row('0, '0),
      frame_row(RATIO_MAX, ONE_Q16)
    };

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        wait_for_idle();
        write_reg(script[i].addr, script[i].data);
      end else begin
        send_frame(script[i].tr, script[i].rr, script[i].typed, script[i].want);
        script_frames++;
      end
    end

    while (random_frames < RANDOM_FRAMES) begin
      wait_for_idle();
      for (int r = REG_TRANS_THRESHOLD; r <= REG_EXIT_FRAMES; r++) begin
        if ($urandom_range(0, 2) == 0) write_reg(ADDR_W'(r), pick_setting(ADDR_W'(r)));
      end
      if ($urandom_range(0, 15) == 0) write_reg(UNUSED_REG_ADDR, QW'($urandom));
      phase_left = $urandom_range(40, 200);
      while (phase_left > 0 && random_frames < RANDOM_FRAMES) begin
        seg_kind = $urandom_range(0, 9);
        seg_len = $urandom_range(1, 40);
        while (seg_len > 0 && phase_left > 0 && random_frames < RANDOM_FRAMES) begin
          case (seg_kind)
            0, 1, 2: begin
              tr = ratio_below(cfg_trans_thr);
              rr = QW'($urandom);
            end
            3, 4: begin
              tr = QW'($urandom);
              rr = ratio_below(cfg_rot_thr);
            end
            5, 6, 7, 8: begin
              tr = ratio_above(cfg_trans_thr);
              rr = ratio_above(cfg_rot_thr);
            end
            default: begin
              tr = QW'($urandom);
              rr = QW'($urandom);
            end
          endcase
          send_frame(tr, rr, 1'b0, '0);
          seg_len--;
          phase_left--;
          random_frames++;
        end
      end
    end

    wait_for_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Ran %0d scripted and %0d random frames across %0d register writes.",
             script_frames, random_frames, reg_writes);
    $display("Checked %0d results, %0d of them flagged degenerate; %0d mismatches.",
             results_checked, degenerate_results, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/ehdf_pkg.sv
sv/ehdf_div.sv
sv/ema_hysteresis_degeneracy_flag_core.sv
tb/tb_top.sv
